/* hw/rtl/pfs_pkg.sv */
// Package: shared types, codes and constants for the packet flow statistics block.
`timescale 1ns / 1ps
package pfs_pkg;

  localparam int ADDR_DEPTH_DEF = 1024;
  localparam int FLOW_DEPTH_DEF = 4096;
  localparam int BIN_COUNT_DEF  = 10;

  localparam logic [7:0] PROTO_TCP   = 8'd6;
  localparam logic [7:0] PROTO_UDP   = 8'd17;
  localparam logic [7:0] PROTO_RESET = 8'd6;

  // length/100 == (length>>2)/25 == ((length>>2) * 10486) >> 18 for 14-bit operands
  localparam int BIN_MULT  = 10486;
  localparam int BIN_SHIFT = 18;

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_ON   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_ADDR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_ON   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_ADDR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTO_ON = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTO   = 3'd5;

  localparam logic [1:0] FLOW_NONE = 2'd0;
  localparam logic [1:0] FLOW_HIT  = 2'd1;
  localparam logic [1:0] FLOW_NEW  = 2'd2;
  localparam logic [1:0] FLOW_FULL = 2'd3;

  localparam logic [1:0] TBL_SRC  = 2'd0;
  localparam logic [1:0] TBL_DST  = 2'd1;
  localparam logic [1:0] TBL_FLOW = 2'd2;

  typedef struct packed {
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [7:0]  proto;
    logic [15:0] source_port;
    logic [15:0] dst_port;
    logic [15:0] packet_length;
  } in_item_t;

  typedef struct packed {
    logic        passed;
    logic [1:0]  flow_result;
    logic [31:0] flow_packets;
    logic [31:0] flow_bytes;
    logic [31:0] src_seen;
    logic [31:0] dst_seen;
    logic [31:0] total_packets;
    logic [31:0] total_octets;
    logic [15:0] smallest_length;
    logic [15:0] largest_length;
    logic [3:0]  size_bin;
    logic [31:0] bin_total;
  } out_item_t;

  typedef struct packed {
    logic       load_pkt;
    logic       scan_start;
    logic       scanning;
    logic [1:0] tbl;
    logic       addr_upd;
    logic       flow_upd;
    logic       stats_upd;
    logic       out_load;
  } pfs_cmd_t;

  typedef struct packed {
    logic hit;
    logic scan_end;
    logic flow_go;
  } pfs_status_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

/* hw/rtl/pfs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/pfs_ctrl.sv */
// Sequencer: runs the address, optional flow and statistics phases per packet.
`timescale 1ns / 1ps
module pfs_ctrl
  import pfs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  pfs_status_t status,
  output pfs_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SRC_SCAN  = 4'd1;
  localparam logic [3:0] S_SRC_UPD   = 4'd2;
  localparam logic [3:0] S_DST_SCAN  = 4'd3;
  localparam logic [3:0] S_DST_UPD   = 4'd4;
  localparam logic [3:0] S_FLOW_SCAN = 4'd5;
  localparam logic [3:0] S_FLOW_UPD  = 4'd6;
  localparam logic [3:0] S_STATS     = 4'd7;
  localparam logic [3:0] S_DONE      = 4'd8;

  logic [3:0] state, state_next;
  logic       out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_pkt   = 1'b1;
          cmd.scan_start = 1'b1;
          state_next     = S_SRC_SCAN;
        end
      end
      S_SRC_SCAN: begin
        cmd.scanning = 1'b1;
        cmd.tbl      = TBL_SRC;
        if (status.hit || status.scan_end) begin
          state_next = S_SRC_UPD;
        end
      end
      S_SRC_UPD: begin
        cmd.addr_upd   = 1'b1;
        cmd.tbl        = TBL_SRC;
        cmd.scan_start = 1'b1;
        state_next     = S_DST_SCAN;
      end
      S_DST_SCAN: begin
        cmd.scanning = 1'b1;
        cmd.tbl      = TBL_DST;
        if (status.hit || status.scan_end) begin
          state_next = S_DST_UPD;
        end
      end
      S_DST_UPD: begin
        cmd.addr_upd   = 1'b1;
        cmd.tbl        = TBL_DST;
        cmd.scan_start = 1'b1;
        state_next     = status.flow_go ? S_FLOW_SCAN : S_STATS;
      end
      S_FLOW_SCAN: begin
        cmd.scanning = 1'b1;
        cmd.tbl      = TBL_FLOW;
        if (status.hit || status.scan_end) begin
          state_next = S_FLOW_UPD;
        end
      end
      S_FLOW_UPD: begin
        cmd.flow_upd = 1'b1;
        cmd.tbl      = TBL_FLOW;
        state_next   = S_STATS;
      end
      S_STATS: begin
        cmd.stats_upd = 1'b1;
        state_next    = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/pfs_dp.sv */
// Datapath: tables, scan engine, filters, flow update and global statistics.
`timescale 1ns / 1ps
module pfs_dp
  import pfs_pkg::*;
#(
  parameter int ADDR_DEPTH = ADDR_DEPTH_DEF,
  parameter int FLOW_DEPTH = FLOW_DEPTH_DEF,
  parameter int BIN_COUNT  = BIN_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  in_item_t             in_data,
  input  pfs_cmd_t             cmd,
  output pfs_status_t          status,
  output out_item_t            out_data
);

  localparam int AAW = (ADDR_DEPTH > 1) ? $clog2(ADDR_DEPTH) : 1;
  localparam int FAW = (FLOW_DEPTH > 1) ? $clog2(FLOW_DEPTH) : 1;
  localparam int UAW = $clog2(ADDR_DEPTH + 1);
  localparam int UFW = $clog2(FLOW_DEPTH + 1);
  localparam int IW  = (UFW > UAW) ? UFW : UAW;
  localparam int BW  = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int AEW = 64;
  localparam int FEW = 160;

  // configuration
  logic        src_on, dst_on, proto_on;
  logic [31:0] src_match, dst_match;
  logic [7:0]  proto_match;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_on      <= 1'b0;
      src_match   <= '0;
      dst_on      <= 1'b0;
      dst_match   <= '0;
      proto_on    <= 1'b0;
      proto_match <= PROTO_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SRC_ON:   src_on      <= cfg_data[0];
        CFG_SRC_ADDR: src_match   <= cfg_data;
        CFG_DST_ON:   dst_on      <= cfg_data[0];
        CFG_DST_ADDR: dst_match   <= cfg_data;
        CFG_PROTO_ON: proto_on    <= cfg_data[0];
        CFG_PROTO:    proto_match <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  in_item_t pkt;
  always_ff @(posedge clk) begin
    if (cmd.load_pkt) begin
      pkt <= in_data;
    end
  end

  logic pass;
  assign pass = (!src_on || pkt.src_addr == src_match) &&
                (!dst_on || pkt.dst_addr == dst_match) &&
                (!proto_on || pkt.proto == proto_match);
  assign status.flow_go = pass && (pkt.proto == PROTO_TCP || pkt.proto == PROTO_UDP);

  // size bin through a reciprocal multiply
  logic [27:0]   bin_prod;
  logic [9:0]    bin_quot;
  logic [BW-1:0] bin_idx;
  always_ff @(posedge clk) begin
    bin_prod <= 28'(pkt.packet_length[15:2]) * 28'(BIN_MULT);
  end
  assign bin_quot = bin_prod[BIN_SHIFT +: 10];
  assign bin_idx  = (bin_quot > 10'(BIN_COUNT - 1)) ? BW'(BIN_COUNT - 1) : BW'(bin_quot);

  // tables
  logic [UAW-1:0] src_used, dst_used;
  logic [UFW-1:0] flow_used;
  logic [AEW-1:0] src_rd, dst_rd, src_wd, dst_wd;
  logic [FEW-1:0] flow_rd, flow_wd;
  logic           src_we, dst_we, flow_we;
  logic           src_re, dst_re, flow_re;
  logic [AAW-1:0] src_wa, dst_wa;
  logic [FAW-1:0] flow_wa;

  logic [IW-1:0] idx, pidx, used_sel;
  logic          pv, found, match, rd_go, more;
  logic [95:0]   flow_tag;

  assign flow_tag = {pkt.src_addr, pkt.dst_addr, pkt.source_port, pkt.dst_port};

  always_comb begin
    case (cmd.tbl)
      TBL_SRC: begin
        used_sel = IW'(src_used);
        match    = (src_rd[63:32] == pkt.src_addr);
      end
      TBL_DST: begin
        used_sel = IW'(dst_used);
        match    = (dst_rd[63:32] == pkt.dst_addr);
      end
      default: begin
        used_sel = IW'(flow_used);
        match    = (flow_rd[159:64] == flow_tag);
      end
    endcase
  end

  assign more            = (idx < used_sel);
  assign status.hit      = cmd.scanning && pv && match;
  assign status.scan_end = cmd.scanning && !pv && !more;
  assign rd_go           = cmd.scanning && !status.hit && more;

  assign src_re  = rd_go && (cmd.tbl == TBL_SRC);
  assign dst_re  = rd_go && (cmd.tbl == TBL_DST);
  assign flow_re = rd_go && (cmd.tbl == TBL_FLOW);

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      idx <= '0;
      pv  <= 1'b0;
    end else if (cmd.scanning) begin
      pv <= rd_go;
      if (rd_go) begin
        idx  <= idx + 1'b1;
        pidx <= idx;
      end
      if (status.hit || status.scan_end) begin
        found <= status.hit;
      end
    end
  end

  // address updates
  logic [31:0] src_inc, dst_inc;
  logic        src_room, dst_room, flow_room;
  assign src_inc   = sat_add32(src_rd[31:0], 32'd1);
  assign dst_inc   = sat_add32(dst_rd[31:0], 32'd1);
  assign src_room  = (src_used < UAW'(ADDR_DEPTH));
  assign dst_room  = (dst_used < UAW'(ADDR_DEPTH));
  assign flow_room = (flow_used < UFW'(FLOW_DEPTH));

  logic        upd_src, upd_dst;
  assign upd_src = cmd.addr_upd && (cmd.tbl == TBL_SRC);
  assign upd_dst = cmd.addr_upd && (cmd.tbl == TBL_DST);

  assign src_we = upd_src && (found || src_room);
  assign src_wa = found ? pidx[AAW-1:0] : src_used[AAW-1:0];
  assign src_wd = {pkt.src_addr, found ? src_inc : 32'd1};
  assign dst_we = upd_dst && (found || dst_room);
  assign dst_wa = found ? pidx[AAW-1:0] : dst_used[AAW-1:0];
  assign dst_wd = {pkt.dst_addr, found ? dst_inc : 32'd1};

  logic [31:0] flow_pk_inc, flow_by_inc, pkt_len32;
  assign pkt_len32   = {16'd0, pkt.packet_length};
  assign flow_pk_inc = sat_add32(flow_rd[63:32], 32'd1);
  assign flow_by_inc = sat_add32(flow_rd[31:0], pkt_len32);
  assign flow_we     = cmd.flow_upd && (found || flow_room);
  assign flow_wa     = found ? pidx[FAW-1:0] : flow_used[FAW-1:0];
  assign flow_wd     = found ? {flow_tag, flow_pk_inc, flow_by_inc}
                             : {flow_tag, 32'd1, pkt_len32};

  pfs_ram #(.WIDTH(AEW), .DEPTH(ADDR_DEPTH)) u_src_ram (
    .clk(clk), .we(src_we), .waddr(src_wa), .wdata(src_wd),
    .re(src_re), .raddr(idx[AAW-1:0]), .rdata(src_rd)
  );
  pfs_ram #(.WIDTH(AEW), .DEPTH(ADDR_DEPTH)) u_dst_ram (
    .clk(clk), .we(dst_we), .waddr(dst_wa), .wdata(dst_wd),
    .re(dst_re), .raddr(idx[AAW-1:0]), .rdata(dst_rd)
  );
  pfs_ram #(.WIDTH(FEW), .DEPTH(FLOW_DEPTH)) u_flow_ram (
    .clk(clk), .we(flow_we), .waddr(flow_wa), .wdata(flow_wd),
    .re(flow_re), .raddr(idx[FAW-1:0]), .rdata(flow_rd)
  );

  // per-packet results and global statistics
  logic [31:0] s_seen, d_seen, fpk, fby, bin_tot;
  logic [1:0]  fres;
  logic [31:0] pkt_total, byte_total;
  logic [15:0] min_len, max_len;
  logic [31:0] bin_cnt [BIN_COUNT];
  logic [31:0] bin_inc;
  assign bin_inc = sat_add32(bin_cnt[bin_idx], 32'd1);

  always_ff @(posedge clk) begin
    if (cmd.load_pkt) begin
      fres <= FLOW_NONE;
      fpk  <= '0;
      fby  <= '0;
    end
    if (upd_src) begin
      s_seen <= found ? src_inc : (src_room ? 32'd1 : 32'd0);
    end
    if (upd_dst) begin
      d_seen <= found ? dst_inc : (dst_room ? 32'd1 : 32'd0);
    end
    if (cmd.flow_upd) begin
      if (found) begin
        fres <= FLOW_HIT;
        fpk  <= flow_pk_inc;
        fby  <= flow_by_inc;
      end else if (flow_room) begin
        fres <= FLOW_NEW;
        fpk  <= 32'd1;
        fby  <= pkt_len32;
      end else begin
        fres <= FLOW_FULL;
      end
    end
    if (cmd.stats_upd) begin
      bin_tot <= pass ? bin_inc : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      src_used   <= '0;
      dst_used   <= '0;
      flow_used  <= '0;
      pkt_total  <= '0;
      byte_total <= '0;
      min_len    <= 16'hFFFF;
      max_len    <= '0;
      for (int i = 0; i < BIN_COUNT; i++) begin
        bin_cnt[i] <= '0;
      end
    end else begin
      if (upd_src && !found && src_room) begin
        src_used <= src_used + 1'b1;
      end
      if (upd_dst && !found && dst_room) begin
        dst_used <= dst_used + 1'b1;
      end
      if (cmd.flow_upd && !found && flow_room) begin
        flow_used <= flow_used + 1'b1;
      end
      if (cmd.stats_upd && pass) begin
        pkt_total  <= sat_add32(pkt_total, 32'd1);
        byte_total <= sat_add32(byte_total, pkt_len32);
        if (pkt.packet_length < min_len) begin
          min_len <= pkt.packet_length;
        end
        if (pkt.packet_length > max_len) begin
          max_len <= pkt.packet_length;
        end
        bin_cnt[bin_idx] <= bin_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.passed          <= pass;
      out_data.flow_result     <= fres;
      out_data.flow_packets    <= fpk;
      out_data.flow_bytes      <= fby;
      out_data.src_seen        <= s_seen;
      out_data.dst_seen        <= d_seen;
      out_data.total_packets   <= pkt_total;
      out_data.total_octets    <= byte_total;
      out_data.smallest_length <= (pkt_total == 32'd0) ? 16'd0 : min_len;
      out_data.largest_length  <= max_len;
      out_data.size_bin        <= 4'(bin_idx);
      out_data.bin_total       <= bin_tot;
    end
  end

endmodule

/* hw/rtl/packet_flow_statistics.sv */
// Top level of the packet flow statistics engine.
`timescale 1ns / 1ps
// One parsed IPv4 header enters per transaction and one result transaction leaves for it.
// Each packet walks its tables with a single read port per table, one entry per cycle:
// the source table (the entries read up to a hit, or the whole used part on a miss),
// then the destination table (same), then, for a passing TCP or UDP packet, the flow
// table (same), each then updated; then statistics and output load steps. The worst case,
// a miss in every table, is set by these linear table scans. One packet is in work at a
// time, but a new one is taken while the previous result still waits in the output
// register; a result that is still waiting when the next one is ready holds the engine.
// Address and flow tables need no clearing after reset: only entries below their fill
// counts are read. Filters are to be written by the user through the cfg port while
// idle; the block itself does not enforce this.
module packet_flow_statistics
  import pfs_pkg::*;
#(
  parameter int ADDR_DEPTH = ADDR_DEPTH_DEF,
  parameter int FLOW_DEPTH = FLOW_DEPTH_DEF,
  parameter int BIN_COUNT  = BIN_COUNT_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  pfs_cmd_t    cmd;
  pfs_status_t status;

  // sequencer: advance through the scan and update phases
  pfs_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .cmd(cmd)
  );

  // datapath: hold tables, counters and the output transaction
  pfs_dp #(
    .ADDR_DEPTH(ADDR_DEPTH), .FLOW_DEPTH(FLOW_DEPTH), .BIN_COUNT(BIN_COUNT)
  ) u_dp (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_data(in_data), .cmd(cmd), .status(status), .out_data(out_data)
  );

endmodule

/* sim/packet_flow_statistics_tb.sv */
// Testbench for the packet flow statistics engine: directed and random packets with a scoreboard.
`timescale 1ns / 1ps
module packet_flow_statistics_tb;
  import pfs_pkg::*;

  localparam int NUM_ADDR  = ADDR_DEPTH_DEF;
  localparam int NUM_FLOW  = FLOW_DEPTH_DEF;
  localparam int NUM_BINS  = BIN_COUNT_DEF;
  localparam int RAND_PKTS = 140;
  localparam longint CYCLE_LIMIT = 4_000_000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;

  packet_flow_statistics dut (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Shadow copy of the filter registers.
  logic        flt_src_on, flt_dst_on, flt_proto_on;
  logic [31:0] flt_src_addr, flt_dst_addr;
  logic [7:0]  flt_proto;

  // Shadow copy of the tables and statistics.
  logic [31:0] src_key_mem [NUM_ADDR];
  logic [31:0] src_cnt_mem [NUM_ADDR];
  int          src_fill;
  logic [31:0] dst_key_mem [NUM_ADDR];
  logic [31:0] dst_cnt_mem [NUM_ADDR];
  int          dst_fill;
  logic [63:0] flow_key_mem  [NUM_FLOW];
  logic [31:0] flow_port_mem [NUM_FLOW];
  logic [31:0] flow_pkt_mem  [NUM_FLOW];
  logic [31:0] flow_byte_mem [NUM_FLOW];
  int          flow_fill;
  logic [31:0] pass_count, octet_sum;
  logic [15:0] len_min, len_max;
  logic [31:0] bin_count [NUM_BINS];

  out_item_t expected_q [$];
  int        error_count;
  int        results_seen;
  int        passed_seen, flows_new, flows_hit;
  longint    cycle_count;
  logic      rx_hold;    // receiver long stall request
  bit        rx_no_idle; // last stretch without stalls
  bit        tx_no_idle;

  function automatic logic [31:0] sat_inc(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  task automatic predict_packet(input in_item_t pkt, output out_item_t res);
    logic        ok;
    logic [63:0] key;
    logic [31:0] ports;
    int          bin;
    int          i;
    bit          found;
    res = '0;
    // Count source address.
    found = 0;
    for (i = 0; i < src_fill; i++) begin
      if (!found && src_key_mem[i] == pkt.src_addr) begin
        src_cnt_mem[i] = sat_inc(src_cnt_mem[i], 1);
        res.src_seen = src_cnt_mem[i];
        found = 1;
      end
    end
    if (!found && src_fill < NUM_ADDR) begin
      src_key_mem[src_fill] = pkt.src_addr;
      src_cnt_mem[src_fill] = 1;
      src_fill++;
      res.src_seen = 1;
    end
    // Count destination address.
    found = 0;
    for (i = 0; i < dst_fill; i++) begin
      if (!found && dst_key_mem[i] == pkt.dst_addr) begin
        dst_cnt_mem[i] = sat_inc(dst_cnt_mem[i], 1);
        res.dst_seen = dst_cnt_mem[i];
        found = 1;
      end
    end
    if (!found && dst_fill < NUM_ADDR) begin
      dst_key_mem[dst_fill] = pkt.dst_addr;
      dst_cnt_mem[dst_fill] = 1;
      dst_fill++;
      res.dst_seen = 1;
    end
    ok = (!flt_src_on || pkt.src_addr == flt_src_addr) &&
         (!flt_dst_on || pkt.dst_addr == flt_dst_addr) &&
         (!flt_proto_on || pkt.proto == flt_proto);
    bin = pkt.packet_length / 100;
    if (bin > NUM_BINS - 1) bin = NUM_BINS - 1;
    res.passed = ok;
    res.flow_result = FLOW_NONE;
    if (ok) begin
      if (pkt.proto == PROTO_TCP || pkt.proto == PROTO_UDP) begin
        key = {pkt.src_addr, pkt.dst_addr};
        ports = {pkt.source_port, pkt.dst_port};
        res.flow_result = FLOW_FULL;
        for (i = 0; i < flow_fill; i++) begin
          if (res.flow_result == FLOW_FULL && flow_key_mem[i] == key &&
              flow_port_mem[i] == ports) begin
            flow_pkt_mem[i] = sat_inc(flow_pkt_mem[i], 1);
            flow_byte_mem[i] = sat_inc(flow_byte_mem[i], pkt.packet_length);
            res.flow_packets = flow_pkt_mem[i];
            res.flow_bytes = flow_byte_mem[i];
            res.flow_result = FLOW_HIT;
          end
        end
        if (res.flow_result == FLOW_FULL && flow_fill < NUM_FLOW) begin
          flow_key_mem[flow_fill] = key;
          flow_port_mem[flow_fill] = ports;
          flow_pkt_mem[flow_fill] = 1;
          flow_byte_mem[flow_fill] = pkt.packet_length;
          flow_fill++;
          res.flow_packets = 1;
          res.flow_bytes = pkt.packet_length;
          res.flow_result = FLOW_NEW;
        end
      end
      pass_count = sat_inc(pass_count, 1);
      octet_sum = sat_inc(octet_sum, pkt.packet_length);
      if (pkt.packet_length < len_min) len_min = pkt.packet_length;
      if (pkt.packet_length > len_max) len_max = pkt.packet_length;
      bin_count[bin] = sat_inc(bin_count[bin], 1);
      res.bin_total = bin_count[bin];
    end
    res.total_packets = pass_count;
    res.total_octets = octet_sum;
    res.smallest_length = (pass_count == 0) ? 16'd0 : len_min;
    res.largest_length = len_max;
    res.size_bin = bin[3:0];
  endtask

  task automatic reset_model();
    flt_src_on = 0; flt_src_addr = 0; flt_dst_on = 0; flt_dst_addr = 0;
    flt_proto_on = 0; flt_proto = PROTO_RESET;
    src_fill = 0; dst_fill = 0; flow_fill = 0;
    pass_count = 0; octet_sum = 0; len_min = 16'hFFFF; len_max = 0;
    for (int i = 0; i < NUM_BINS; i++) bin_count[i] = 0;
  endtask

  // Write one filter register and mirror it in the shadow copy.
  task automatic write_filter(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SRC_ON:   flt_src_on = val[0];
      CFG_SRC_ADDR: flt_src_addr = val;
      CFG_DST_ON:   flt_dst_on = val[0];
      CFG_DST_ADDR: flt_dst_addr = val;
      CFG_PROTO_ON: flt_proto_on = val[0];
      CFG_PROTO:    flt_proto = val[7:0];
      default: ;
    endcase
  endtask

  // Wait for every outstanding result, then let the block run on until it is idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Offer one transaction; predict it at the accepting edge.
  task automatic send_packet(input in_item_t pkt, input bit may_idle);
    out_item_t res;
    if (may_idle && !tx_no_idle && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= pkt;
    do @(posedge clk); while (!in_ready);
    predict_packet(pkt, res);
    expected_q.push_back(res);
  endtask

  // Receiver: random stall bursts, a long hold on request, none near the end.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        out_ready <= 1'b0;
      end else if (!rx_no_idle && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Check every accepted result against the oldest expectation.
  always @(posedge clk) begin
    out_item_t exp_res;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction");
        error_count++;
      end else begin
        exp_res = expected_q.pop_front();
        if (out_data.passed) passed_seen++;
        if (out_data.flow_result == FLOW_NEW) flows_new++;
        if (out_data.flow_result == FLOW_HIT) flows_hit++;
        if (out_data.passed !== exp_res.passed) begin
          $error("passed exp %0d got %0d", exp_res.passed, out_data.passed); error_count++;
        end
        if (out_data.flow_result !== exp_res.flow_result) begin
          $error("flow_result exp %0d got %0d", exp_res.flow_result, out_data.flow_result);
          error_count++;
        end
        if (out_data.flow_packets !== exp_res.flow_packets) begin
          $error("flow_packets exp %0d got %0d", exp_res.flow_packets, out_data.flow_packets);
          error_count++;
        end
        if (out_data.flow_bytes !== exp_res.flow_bytes) begin
          $error("flow_bytes exp %0d got %0d", exp_res.flow_bytes, out_data.flow_bytes);
          error_count++;
        end
        if (out_data.src_seen !== exp_res.src_seen) begin
          $error("src_seen exp %0d got %0d", exp_res.src_seen, out_data.src_seen);
          error_count++;
        end
        if (out_data.dst_seen !== exp_res.dst_seen) begin
          $error("dst_seen exp %0d got %0d", exp_res.dst_seen, out_data.dst_seen);
          error_count++;
        end
        if (out_data.total_packets !== exp_res.total_packets) begin
          $error("total_packets exp %0d got %0d", exp_res.total_packets,
                 out_data.total_packets);
          error_count++;
        end
        if (out_data.total_octets !== exp_res.total_octets) begin
          $error("total_octets exp %0d got %0d", exp_res.total_octets, out_data.total_octets);
          error_count++;
        end
        if (out_data.smallest_length !== exp_res.smallest_length) begin
          $error("smallest_length exp %0d got %0d", exp_res.smallest_length,
                 out_data.smallest_length);
          error_count++;
        end
        if (out_data.largest_length !== exp_res.largest_length) begin
          $error("largest_length exp %0d got %0d", exp_res.largest_length,
                 out_data.largest_length);
          error_count++;
        end
        if (out_data.size_bin !== exp_res.size_bin) begin
          $error("size_bin exp %0d got %0d", exp_res.size_bin, out_data.size_bin);
          error_count++;
        end
        if (out_data.bin_total !== exp_res.bin_total) begin
          $error("bin_total exp %0d got %0d", exp_res.bin_total, out_data.bin_total);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if it hangs.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // Directed table. The typed-in result is checked only where check_row is set;
  // every row is also checked against the predictor.
  typedef struct {
    in_item_t  pkt;
    bit        check_row;
    out_item_t known;
  } dir_row_t;

  dir_row_t dir_rows [$];

  function automatic in_item_t mk_pkt(logic [31:0] sa, logic [31:0] da, logic [7:0] pr,
                                      logic [15:0] sp, logic [15:0] dp, logic [15:0] len);
    in_item_t p;
    p = '{src_addr: sa, dst_addr: da, proto: pr, source_port: sp, dst_port: dp,
          packet_length: len};
    return p;
  endfunction

  // Random packet drawn from a small address and port pool so that hits dominate.
  function automatic in_item_t rand_pkt();
    in_item_t p;
    int sel;
    sel = $urandom_range(0, 9);
    p.src_addr = (sel < 8) ? 32'h0A00_0000 + $urandom_range(0, 7) : $urandom();
    p.dst_addr = (sel < 8) ? 32'hC0A8_0000 + $urandom_range(0, 7) : $urandom();
    case ($urandom_range(0, 5))
      0, 1, 2: p.proto = PROTO_TCP;
      3, 4:    p.proto = PROTO_UDP;
      default: p.proto = 8'($urandom_range(0, 255));
    endcase
    p.source_port = (sel < 7) ? 16'(1000 + $urandom_range(0, 3)) : 16'($urandom());
    p.dst_port = (sel < 7) ? 16'(80 + $urandom_range(0, 1)) : 16'($urandom());
    p.packet_length = ($urandom_range(0, 7) == 0) ? 16'($urandom()) :
                      16'($urandom_range(0, 1100));
    return p;
  endfunction

  initial begin
    out_item_t k;
    in_item_t  p;
    error_count = 0; results_seen = 0; passed_seen = 0; flows_new = 0; flows_hit = 0;
    rx_hold = 0; rx_no_idle = 0; tx_no_idle = 0;
    rst = 1'b1;
    cfg_wr_en = 1'b0; cfg_index = CFG_SRC_ON; cfg_data = '0;
    in_valid = 1'b0; in_data = '0;
    reset_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // First packet after reset: all counts are one, plain TCP, new flow.
    k = '0;
    k.passed = 1; k.flow_result = FLOW_NEW; k.flow_packets = 1; k.flow_bytes = 0;
    k.src_seen = 1; k.dst_seen = 1; k.total_packets = 1; k.total_octets = 0;
    k.smallest_length = 0; k.largest_length = 0; k.size_bin = 0; k.bin_total = 1;
    dir_rows.push_back('{mk_pkt(0, 0, PROTO_TCP, 0, 0, 0), 1, k});
    // All-ones fields, UDP, open-ended top bin.
    k = '0;
    k.passed = 1; k.flow_result = FLOW_NEW; k.flow_packets = 1; k.flow_bytes = 65535;
    k.src_seen = 1; k.dst_seen = 1; k.total_packets = 2; k.total_octets = 65535;
    k.smallest_length = 0; k.largest_length = 65535; k.size_bin = 9; k.bin_total = 1;
    dir_rows.push_back('{mk_pkt('1, '1, PROTO_UDP, '1, '1, '1), 1, k});
    // Same flow again: existing flow.
    dir_rows.push_back('{mk_pkt('1, '1, PROTO_UDP, '1, '1, 16'd100), 0, k});
    // Other protocols: no flow update.
    dir_rows.push_back('{mk_pkt(32'h0102_0304, 32'h0506_0708, 8'd1, 16'h5555, 16'hAAAA,
                                16'd99), 0, k});
    dir_rows.push_back('{mk_pkt(32'h5555_5555, 32'hAAAA_AAAA, 8'hFF, 16'h1234, 16'h4321,
                                16'd999), 0, k});
    dir_rows.push_back('{mk_pkt(32'hAAAA_AAAA, 32'h5555_5555, 8'hAA, 16'hAAAA, 16'h5555,
                                16'd1000), 0, k});
    // Bin edges.
    dir_rows.push_back('{mk_pkt(32'h0A00_0001, 32'h0A00_0002, PROTO_TCP, 16'd1, 16'd2,
                                16'd199), 0, k});
    dir_rows.push_back('{mk_pkt(32'h0A00_0001, 32'h0A00_0002, PROTO_TCP, 16'd1, 16'd2,
                                16'd200), 0, k});
    dir_rows.push_back('{mk_pkt(32'h0A00_0001, 32'h0A00_0002, PROTO_TCP, 16'd1, 16'd3,
                                16'd899), 0, k});
    dir_rows.push_back('{mk_pkt(32'h0A00_0001, 32'h0A00_0002, PROTO_UDP, 16'd1, 16'd2,
                                16'd900), 0, k});
    foreach (dir_rows[r]) begin
      send_packet(dir_rows[r].pkt, 1);
      if (dir_rows[r].check_row && expected_q[$] != dir_rows[r].known) begin
        $error("directed row %0d: prediction differs from typed-in result", r);
        error_count++;
      end
    end
    drain_results();

    // Filters at their extremes; rejected packets leave the global statistics alone.
    write_filter(CFG_SRC_ON, 1);
    write_filter(CFG_SRC_ADDR, 32'hFFFF_FFFF);
    write_filter(CFG_DST_ON, 1);
    write_filter(CFG_DST_ADDR, 32'hFFFF_FFFF);
    write_filter(CFG_PROTO_ON, 1);
    write_filter(CFG_PROTO, PROTO_UDP);
    send_packet(mk_pkt('1, '1, PROTO_UDP, '1, '1, 16'd5), 1);
    send_packet(mk_pkt('1, 0, PROTO_UDP, '1, '1, 16'd5), 1);
    send_packet(mk_pkt(0, '1, PROTO_UDP, 0, 0, 16'd5), 1);
    send_packet(mk_pkt('1, '1, PROTO_TCP, 0, 0, 16'd5), 1);
    drain_results();
    write_filter(CFG_SRC_ADDR, 32'h0000_0000);
    write_filter(CFG_DST_ON, 0);
    write_filter(CFG_PROTO, 8'hFF);
    send_packet(mk_pkt(0, 32'h1234_5678, 8'hFF, 1, 1, 16'd50), 1);
    send_packet(mk_pkt(0, 32'h1234_5678, PROTO_TCP, 1, 1, 16'd50), 1);
    drain_results();

    // Random phases with different filter settings.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          write_filter(CFG_SRC_ON, 0); write_filter(CFG_DST_ON, 0);
          write_filter(CFG_PROTO_ON, 0);
        end
        1: begin
          write_filter(CFG_PROTO_ON, 1); write_filter(CFG_PROTO, PROTO_TCP);
        end
        2: begin
          write_filter(CFG_PROTO_ON, 0); write_filter(CFG_SRC_ON, 1);
          write_filter(CFG_SRC_ADDR, 32'h0A00_0000 + $urandom_range(0, 7));
          write_filter(CFG_DST_ON, 1);
          write_filter(CFG_DST_ADDR, 32'hC0A8_0000 + $urandom_range(0, 7));
        end
        default: begin
          write_filter(CFG_SRC_ON, 0); write_filter(CFG_DST_ON, 0);
          tx_no_idle = 1; rx_no_idle = 1;
        end
      endcase
      // Hold the receiver off for a long stretch while the sender keeps offering.
      if (phase == 1) begin
        rx_hold = 1;
        fork
          begin
            repeat (400) @(posedge clk);
            rx_hold = 0;
          end
        join_none
      end
      for (int n = 0; n < RAND_PKTS / 4; n++) begin
        p = rand_pkt();
        send_packet(p, 1);
      end
      drain_results();
    end

    $display("covered %0d results: %0d passed, %0d new flows, %0d flow hits",
             results_seen, passed_seen, flows_new, flows_hit);
    $display("filter settings swept at extremes, long output stall and full drain exercised");
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/pfs_pkg.sv
hw/rtl/pfs_ram.sv
hw/rtl/pfs_ctrl.sv
hw/rtl/pfs_dp.sv
hw/rtl/packet_flow_statistics.sv
sim/packet_flow_statistics_tb.sv
